[hw/rtl/dpht_pkg.sv]
// Shared types and constants for the depth-preferred hash table.
package dpht_pkg;

    // Field widths
    localparam int KEY_W      = 64;
    localparam int VALUE_W    = 32;
    localparam int DEPTH_W    = 8;
    localparam int MOVE_W     = 16;
    localparam int FLAG_W     = 8;
    localparam int REQ_W      = 2;
    localparam int PERMILLE_W = 10;
    localparam int USED_W     = 10;

    // Fill ratio arithmetic
    localparam int PERMILLE_SCALE = 1000;
    localparam int SCALED_W       = 20;
    localparam int RECIP_SHIFT    = 30;
    localparam int RECIP_W        = RECIP_SHIFT + 1;
    localparam int PROD_W         = SCALED_W + RECIP_W;

    // Stream bus widths
    localparam int S_TDATA_W = KEY_W + VALUE_W + DEPTH_W + MOVE_W + FLAG_W;
    localparam int M_PAD_W   = 6;
    localparam int M_TDATA_W = VALUE_W + MOVE_W + DEPTH_W + FLAG_W + PERMILLE_W + M_PAD_W;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_STORE = 2'd0,
        REQ_PROBE = 2'd1,
        REQ_FILL  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_e;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_RESULT
    } state_e;

    // Input beat payload, key in the lowest bits
    typedef struct packed {
        logic [FLAG_W-1:0]         bound_flag;
        logic [MOVE_W-1:0]         best_move;
        logic [DEPTH_W-1:0]        depth;
        logic signed [VALUE_W-1:0] value;
        logic [KEY_W-1:0]          key;
    } in_data_t;

    // Packed entry word: flag 63..56, depth 55..48, move 47..32, value 31..0
    typedef struct packed {
        logic [FLAG_W-1:0]         flag;
        logic [DEPTH_W-1:0]        depth;
        logic [MOVE_W-1:0]         move;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One memory slot: check word (key ^ entry) above the entry
    typedef struct packed {
        logic [KEY_W-1:0] check;
        entry_t           entry;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Output beat payload, value in the lowest bits
    typedef struct packed {
        logic [M_PAD_W-1:0]        pad;
        logic [PERMILLE_W-1:0]     fill_permille;
        logic [FLAG_W-1:0]         out_flag;
        logic [DEPTH_W-1:0]        out_depth;
        logic [MOVE_W-1:0]         out_move;
        logic signed [VALUE_W-1:0] out_value;
    } out_data_t;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic rd_en;
        logic div_start;
        logic exec_go;
        logic res_go;
        logic clr_wr;
        logic cnt_clear;
    } ctrl_t;

endpackage

[hw/rtl/dpht_mem.sv]
// Slot memory: one write port, one read port, registered read data.
module dpht_mem
    import dpht_pkg::*;
#(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 128
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/dpht_fill_div.sv]
// Fill ratio unit: used * 1000 / sample size by reciprocal multiply and correction.
module dpht_fill_div
    import dpht_pkg::*;
#(
    parameter int unsigned SAMPLE_SIZE = 1000
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [USED_W-1:0]     used,
    output logic                  done,
    output logic [PERMILLE_W-1:0] quot
);

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / SAMPLE_SIZE);
    localparam logic [USED_W-1:0] DIVISOR = USED_W'(SAMPLE_SIZE);

    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic [SCALED_W-1:0]   scaled_reg;
    logic [SCALED_W-1:0]   num_reg;
    logic [PERMILLE_W-1:0] qest_reg;
    logic [PERMILLE_W-1:0] quot_reg;
    logic [USED_W-1:0]     used_clamped;
    logic [PROD_W-1:0]     prod;
    logic [SCALED_W-1:0]   back;
    logic [SCALED_W-1:0]   rem;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1: clamp and scale by 1000
    assign used_clamped = (used > DIVISOR) ? DIVISOR : used;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            scaled_reg <= SCALED_W'(used_clamped * PERMILLE_SCALE);
        end
    end

    // Stage 2: estimate, low by at most one
    assign prod = PROD_W'(scaled_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            num_reg  <= scaled_reg;
            qest_reg <= prod[RECIP_SHIFT +: PERMILLE_W];
        end
    end

    // Stage 3: remainder check and correction
    assign back = SCALED_W'(qest_reg) * SCALED_W'(DIVISOR);
    assign rem  = num_reg - back;

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            quot_reg <= (rem >= SCALED_W'(DIVISOR)) ? qest_reg + 1'b1 : qest_reg;
        end
    end

    assign done = v3_reg;
    assign quot = quot_reg;

endmodule

[hw/rtl/dpht_ctrl.sv]
// Request sequencer: accept, read-modify-write, fill query, clearing sweep.
module dpht_ctrl
    import dpht_pkg::*;
#(
    parameter int INDEX_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  req_e                  s_req,
    input  logic                  cfg_we,
    input  logic                  out_free,
    input  logic                  div_done,
    output logic                  s_tready,
    output ctrl_t                 ctrl,
    output logic [INDEX_BITS-1:0] clr_addr
);

    state_e                state_reg;
    state_e                state_next;
    logic [INDEX_BITS-1:0] clr_addr_reg;
    logic                  clr_req_reg;
    logic                  accept;
    logic                  clr_last;
    logic                  clr_start;

    assign accept    = (state_reg == ST_IDLE) && s_tvalid;
    assign clr_last  = &clr_addr_reg;
    assign clr_start = accept && (s_req == REQ_CLEAR);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = clr_req_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_req)
                        REQ_STORE: state_next = ST_EXEC;
                        REQ_PROBE: state_next = ST_EXEC;
                        REQ_FILL:  state_next = ST_FILL;
                        default:   state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                if (div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        // New empty code wipes the table
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Outputs
    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        ctrl.rd_en     = accept;
        ctrl.div_start = accept && (s_req == REQ_FILL);
        ctrl.exec_go   = (state_reg == ST_EXEC) && out_free;
        ctrl.res_go    = (state_reg == ST_RESULT) && out_free;
        ctrl.clr_wr    = (state_reg == ST_CLEAR);
        ctrl.cnt_clear = (state_reg == ST_CLEAR);
    end

    // State, sweep address, pending clear result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            clr_req_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we || clr_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (clr_start)
            begin
                clr_req_reg <= 1'b1;
            end
            else if ((state_reg == ST_CLEAR) && clr_last && !cfg_we)
            begin
                clr_req_reg <= 1'b0;
            end
        end
    end

    assign clr_addr = clr_addr_reg;

endmodule

[hw/rtl/depth_preferred_hash_table_top.sv]
// Store/probe: the slot is read at the input beat; in ST_EXEC, once the output register is
// free, a store writes it back and the result is registered; no new request until then.
// Fill query: through the three-stage fill ratio unit, then the result.
// Clear request: a sweep of all 2^INDEX_BITS slots, one slot per cycle, then the result.
// After reset and after every empty_flag_code write the same sweep of all slots runs
// with s_tready low; the empty code resets to 0 and the fill counter to 0.
module depth_preferred_hash_table_top
    import dpht_pkg::*;
#(
    parameter int INDEX_BITS   = 12,
    parameter int SAMPLE_LIMIT = 1000
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key, value, depth, best_move, bound_flag
    input  logic [REQ_W-1:0]     s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_value, out_move, out_depth, out_flag,
                                            // fill_permille, zero pad
    output logic [0:0]           m_tuser,   // found
    input  logic                 cfg_we,
    input  logic [FLAG_W-1:0]    cfg_wdata  // empty_flag_code
);

    localparam int unsigned NUM_SLOTS   = 32'd1 << INDEX_BITS;
    localparam int unsigned SAMPLE_SIZE =
        (NUM_SLOTS < SAMPLE_LIMIT) ? NUM_SLOTS : SAMPLE_LIMIT;

    ctrl_t                 ctrl;
    logic [INDEX_BITS-1:0] clr_addr;
    logic                  div_done;
    logic [PERMILLE_W-1:0] div_q;
    logic                  out_free;

    in_data_t              s_in;
    req_e                  s_req;
    in_data_t              req_reg;
    req_e                  req_type_reg;
    logic [FLAG_W-1:0]     empty_code_reg;
    logic [USED_W-1:0]     used_reg;

    logic [SLOT_W-1:0]     rd_data;
    slot_t                 rd_slot;
    slot_t                 wr_slot;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    logic [INDEX_BITS-1:0] req_idx;

    entry_t                old_entry;
    entry_t                new_entry;
    logic                  was_empty;
    logic                  now_empty;
    logic                  store_ok;
    logic                  hit;
    logic                  in_sample;

    logic                  m_tvalid_reg;
    out_data_t             m_data_reg;
    logic                  m_found_reg;
    out_data_t             res_data;
    logic                  res_found;

    assign s_in     = in_data_t'(s_tdata);
    assign s_req    = req_e'(s_tuser);
    assign out_free = !m_tvalid_reg || m_tready;

    dpht_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_req    (s_req),
        .cfg_we   (cfg_we),
        .out_free (out_free),
        .div_done (div_done),
        .s_tready (s_tready),
        .ctrl     (ctrl),
        .clr_addr (clr_addr)
    );

    dpht_fill_div #(
        .SAMPLE_SIZE (SAMPLE_SIZE)
    ) u_fill_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .used  (used_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    dpht_mem #(
        .ADDR_W (INDEX_BITS),
        .DATA_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_en   (ctrl.rd_en),
        .rd_addr (s_in.key[INDEX_BITS-1:0]),
        .rd_data (rd_data)
    );

    // Request capture at the input beat
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            req_reg      <= s_in;
            req_type_reg <= s_req;
        end
    end

    // Empty code register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_code_reg <= '0;
        end
        else if (cfg_we)
        begin
            empty_code_reg <= cfg_wdata;
        end
    end

    // Slot update and probe match
    assign rd_slot   = slot_t'(rd_data);
    assign old_entry = rd_slot.entry;
    assign req_idx   = req_reg.key[INDEX_BITS-1:0];
    assign was_empty = (old_entry.flag == empty_code_reg);
    assign store_ok  = was_empty || (req_reg.depth >= old_entry.depth);
    assign now_empty = (req_reg.bound_flag == empty_code_reg);
    assign in_sample = (32'(req_idx) < SAMPLE_SIZE);
    assign hit       = !was_empty &&
                       ((rd_slot.check ^ KEY_W'(old_entry)) == req_reg.key);

    always_comb
    begin
        new_entry.flag  = req_reg.bound_flag;
        new_entry.depth = req_reg.depth;
        new_entry.move  = (req_reg.best_move == '0) ? old_entry.move : req_reg.best_move;
        new_entry.value = req_reg.value;
    end

    // Memory write: sweep or store
    always_comb
    begin
        if (ctrl.clr_wr)
        begin
            wr_en              = 1'b1;
            wr_addr            = clr_addr;
            wr_slot.check      = '0;
            wr_slot.entry      = '0;
            wr_slot.entry.flag = empty_code_reg;
        end
        else
        begin
            wr_en         = ctrl.exec_go && (req_type_reg == REQ_STORE) && store_ok;
            wr_addr       = req_idx;
            wr_slot.check = req_reg.key ^ KEY_W'(new_entry);
            wr_slot.entry = new_entry;
        end
    end

    // Used-slot counter over the sampled slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (ctrl.cnt_clear)
        begin
            used_reg <= '0;
        end
        else if (wr_en && in_sample)
        begin
            if (was_empty && !now_empty)
            begin
                used_reg <= used_reg + 1'b1;
            end
            else if (!was_empty && now_empty && (used_reg != '0))
            begin
                used_reg <= used_reg - 1'b1;
            end
        end
    end

    // Result beat contents
    always_comb
    begin
        res_data  = '0;
        res_found = 1'b0;
        case (req_type_reg)
            REQ_STORE:
            begin
                res_found = store_ok;
            end
            REQ_PROBE:
            begin
                if (hit)
                begin
                    res_found          = 1'b1;
                    res_data.out_value = old_entry.value;
                    res_data.out_move  = old_entry.move;
                    res_data.out_depth = old_entry.depth;
                    res_data.out_flag  = old_entry.flag;
                end
            end
            REQ_FILL:
            begin
                res_data.fill_permille = div_q;
            end
            default:
            begin
                res_found = 1'b0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctrl.exec_go || ctrl.res_go)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec_go || ctrl.res_go)
        begin
            m_data_reg  <= res_data;
            m_found_reg <= res_found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

endmodule
